/* hw/rtl/rfps_pkg.sv */
// ----------------------------------------------------------------------------
// rfps_pkg
// Shared widths, codes, reset values and types of the flight phase sequencer.
// ----------------------------------------------------------------------------
package rfps_pkg;

  localparam int unsigned CMD_W      = 8;
  localparam int unsigned ACC_W      = 16;
  localparam int unsigned PRESSURE_W = 25;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned PULSE_W    = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned WINDOW_LEN_DEF = 10;

  // flight phases
  localparam logic [PHASE_W-1:0] PH_WAITING = 3'd0;
  localparam logic [PHASE_W-1:0] PH_POWERED = 3'd1;
  localparam logic [PHASE_W-1:0] PH_COAST   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DESCENT = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LANDED  = 3'd4;

  // uplink commands
  localparam logic [CMD_W-1:0] CMD_ARM        = 8'd1;
  localparam logic [CMD_W-1:0] CMD_DISARM     = 8'd2;
  localparam logic [CMD_W-1:0] CMD_CAMERA_ON  = 8'd5;
  localparam logic [CMD_W-1:0] CMD_CAMERA_OFF = 8'd6;
  localparam logic [CMD_W-1:0] CMD_CHUTE      = 8'd7;
  localparam logic [CMD_W-1:0] CMD_LAUNCH     = 8'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH_ACCEL_SQ  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURNOUT_ACCEL_SQ = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENT_TIMEOUT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUTE_PULSE      = 8'd3;

  // configuration reset values (4 g and 2 g squared at 0.0039 g per count)
  localparam logic [SQ_W-1:0]    LAUNCH_ACCEL_SQ_RST  = 32'd1051940;
  localparam logic [SQ_W-1:0]    BURNOUT_ACCEL_SQ_RST = 32'd262985;
  localparam logic [TIME_W-1:0]  DESCENT_TIMEOUT_RST  = 32'd300000;
  localparam logic [PULSE_W-1:0] CHUTE_PULSE_RST      = 8'd30;

  // one frame after the input register
  typedef struct packed {
    logic                  cmd_valid;
    logic [CMD_W-1:0]      cmd_byte;
    logic [PRESSURE_W-1:0] pressure_q8;
    logic [TIME_W-1:0]     time_ms;
    logic [SQ_W-1:0]       acc_sq;
  } frame_t;

endpackage

/* hw/rtl/rfps_if.sv */
// ----------------------------------------------------------------------------
// rfps_if
// Request channels of the flight phase sequencer: frames in, results out and
// configuration writes.
// ----------------------------------------------------------------------------
interface rfps_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd_valid;
  logic [rfps_pkg::CMD_W-1:0]       cmd_byte;
  logic signed [rfps_pkg::ACC_W-1:0] accel_x;
  logic signed [rfps_pkg::ACC_W-1:0] accel_y;
  logic signed [rfps_pkg::ACC_W-1:0] accel_z;
  logic [rfps_pkg::PRESSURE_W-1:0]  pressure_q8;
  logic [rfps_pkg::TIME_W-1:0]      time_ms;

  modport source (output valid, cmd_valid, cmd_byte, accel_x, accel_y, accel_z,
                  pressure_q8, time_ms, input ready);
  modport sink (input valid, cmd_valid, cmd_byte, accel_x, accel_y, accel_z,
                pressure_q8, time_ms, output ready);
endinterface

interface rfps_out_if;
  logic                          valid;
  logic                          ready;
  logic [rfps_pkg::PHASE_W-1:0]  flight_phase;
  logic                          chute_on;
  logic                          armed_flag;
  logic                          camera_flag;

  modport source (output valid, flight_phase, chute_on, armed_flag, camera_flag,
                  input ready);
  modport sink (input valid, flight_phase, chute_on, armed_flag, camera_flag,
                output ready);
endinterface

interface rfps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rfps_pkg::CFG_IDX_W-1:0]  index;
  logic [rfps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/rfps_in_stage.sv */
// ----------------------------------------------------------------------------
// rfps_in_stage
// Input register; squares the accelerometer counts on the way in.
// ----------------------------------------------------------------------------
module rfps_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  rfps_in_if.sink          in_i,
  output logic             valid_o,
  output rfps_pkg::frame_t frame_o,
  input  logic             ready_i
);

  logic             valid_q;
  rfps_pkg::frame_t frame_q;
  rfps_pkg::frame_t frame_d;
  logic             accept;

  logic [rfps_pkg::ACC_W-1:0] mag_x, mag_y, mag_z;
  logic [rfps_pkg::SQ_W-1:0]  sq_x, sq_y, sq_z;

  // magnitude of a two's complement count; -32768 gives 32768 unsigned
  always_comb begin
    mag_x = in_i.accel_x[rfps_pkg::ACC_W-1] ? rfps_pkg::ACC_W'(-in_i.accel_x)
                                            : rfps_pkg::ACC_W'(in_i.accel_x);
    mag_y = in_i.accel_y[rfps_pkg::ACC_W-1] ? rfps_pkg::ACC_W'(-in_i.accel_y)
                                            : rfps_pkg::ACC_W'(in_i.accel_y);
    mag_z = in_i.accel_z[rfps_pkg::ACC_W-1] ? rfps_pkg::ACC_W'(-in_i.accel_z)
                                            : rfps_pkg::ACC_W'(in_i.accel_z);
    sq_x  = rfps_pkg::SQ_W'(mag_x) * rfps_pkg::SQ_W'(mag_x);
    sq_y  = rfps_pkg::SQ_W'(mag_y) * rfps_pkg::SQ_W'(mag_y);
    sq_z  = rfps_pkg::SQ_W'(mag_z) * rfps_pkg::SQ_W'(mag_z);

    frame_d.cmd_valid   = in_i.cmd_valid;
    frame_d.cmd_byte    = in_i.cmd_byte;
    frame_d.pressure_q8 = in_i.pressure_q8;
    frame_d.time_ms     = in_i.time_ms;
    // three squares of at most 2^30 each stay below 2^32
    frame_d.acc_sq      = sq_x + sq_y + sq_z;
  end

  assign in_i.ready = !valid_q || ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_q <= frame_d;
    end
  end

  assign valid_o = valid_q;
  assign frame_o = frame_q;

endmodule

/* hw/rtl/rfps_window.sv */
// ----------------------------------------------------------------------------
// rfps_window
// Ring of pressure samples with a running sum; flags the push that wraps.
// ----------------------------------------------------------------------------
module rfps_window #(
  parameter int unsigned WINDOW_LEN = rfps_pkg::WINDOW_LEN_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          push_i,
  input  logic [rfps_pkg::PRESSURE_W-1:0]               pressure_i,
  output logic                                          wrap_o,
  output logic [rfps_pkg::PRESSURE_W+$clog2(WINDOW_LEN)-1:0] sum_o
);

  localparam int unsigned SUM_W  = rfps_pkg::PRESSURE_W + $clog2(WINDOW_LEN);
  localparam int unsigned POS_W  = $clog2(WINDOW_LEN);
  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);

  logic [rfps_pkg::PRESSURE_W-1:0] win_q [WINDOW_LEN];
  logic [POS_W-1:0]  pos_q;
  logic [FILL_W-1:0] fill_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]  sum_d;
  logic              full;
  logic              last;

  assign full = (fill_q == FILL_W'(WINDOW_LEN));
  assign last = (pos_q == POS_W'(WINDOW_LEN - 1));

  // drop the oldest sample only once the ring is full
  always_comb begin
    if (full) begin
      sum_d = sum_q - SUM_W'(win_q[pos_q]) + SUM_W'(pressure_i);
    end else begin
      sum_d = sum_q + SUM_W'(pressure_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (push_i) begin
      pos_q <= last ? '0 : pos_q + POS_W'(1);
      if (!full) begin
        fill_q <= fill_q + FILL_W'(1);
      end
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      win_q[pos_q] <= pressure_i;
    end
  end

  assign wrap_o = last;
  assign sum_o  = sum_d;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WINDOW_LEN))
    else $error("window fill beyond its length");

  a_pos_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> (FILL_W'(pos_q) == fill_q))
    else $error("write position out of step with fill while filling");

endmodule

/* hw/rtl/rfps_core.sv */
// ----------------------------------------------------------------------------
// rfps_core
// Command handling, chute pulse, phase transitions and the result register.
// ----------------------------------------------------------------------------
module rfps_core #(
  parameter int unsigned WINDOW_LEN = rfps_pkg::WINDOW_LEN_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  input  rfps_pkg::frame_t                              frame_i,
  output logic                                          ready_o,
  rfps_cfg_if.sink                                      cfg_i,
  rfps_out_if.source                                    out_o,
  output logic                                          push_o,
  output logic [rfps_pkg::PRESSURE_W-1:0]               pressure_o,
  input  logic                                          wrap_i,
  input  logic [rfps_pkg::PRESSURE_W+$clog2(WINDOW_LEN)-1:0] sum_i
);

  localparam int unsigned SUM_W = rfps_pkg::PRESSURE_W + $clog2(WINDOW_LEN);

  // configuration
  logic [rfps_pkg::SQ_W-1:0]    launch_sq_q;
  logic [rfps_pkg::SQ_W-1:0]    burnout_sq_q;
  logic [rfps_pkg::TIME_W-1:0]  timeout_q;
  logic [rfps_pkg::PULSE_W-1:0] pulse_q;

  // flight state
  logic [rfps_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [rfps_pkg::CMD_W-1:0]   last_cmd_q, last_cmd_d;
  logic                         armed_q, armed_d;
  logic                         camera_q, camera_d;
  logic                         fired_q, fired_d;
  logic [rfps_pkg::PULSE_W-1:0] chute_cnt_q, chute_cnt_d;
  logic [SUM_W-1:0]             prev_sum_q, prev_sum_d;
  logic [rfps_pkg::TIME_W-1:0]  start_ms_q, start_ms_d;

  logic [rfps_pkg::PULSE_W-1:0] cnt_mid;
  logic                         chute_on;
  logic [rfps_pkg::TIME_W-1:0]  elapsed;

  // result register
  logic                         out_valid_q;
  logic [rfps_pkg::PHASE_W-1:0] res_phase_q;
  logic                         res_chute_q;
  logic                         res_armed_q;
  logic                         res_camera_q;

  logic proc;

  assign ready_o = !out_valid_q || out_o.ready;
  assign proc    = valid_i && ready_o;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_sq_q  <= rfps_pkg::LAUNCH_ACCEL_SQ_RST;
      burnout_sq_q <= rfps_pkg::BURNOUT_ACCEL_SQ_RST;
      timeout_q    <= rfps_pkg::DESCENT_TIMEOUT_RST;
      pulse_q      <= rfps_pkg::CHUTE_PULSE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rfps_pkg::CFG_LAUNCH_ACCEL_SQ:  launch_sq_q  <= cfg_i.data;
        rfps_pkg::CFG_BURNOUT_ACCEL_SQ: burnout_sq_q <= cfg_i.data;
        rfps_pkg::CFG_DESCENT_TIMEOUT:  timeout_q    <= cfg_i.data;
        rfps_pkg::CFG_CHUTE_PULSE:      pulse_q      <= cfg_i.data[rfps_pkg::PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign push_o     = proc && (phase_q == rfps_pkg::PH_COAST);
  assign pressure_o = frame_i.pressure_q8;
  assign elapsed    = frame_i.time_ms - start_ms_q;

  always_comb begin
    last_cmd_d = last_cmd_q;
    armed_d    = armed_q;
    camera_d   = camera_q;
    fired_d    = fired_q;
    cnt_mid    = chute_cnt_q;

    if (frame_i.cmd_valid) begin
      last_cmd_d = frame_i.cmd_byte;
      case (frame_i.cmd_byte)
        rfps_pkg::CMD_ARM:        armed_d  = 1'b1;
        rfps_pkg::CMD_DISARM:     armed_d  = 1'b0;
        rfps_pkg::CMD_CAMERA_ON:  camera_d = 1'b1;
        rfps_pkg::CMD_CAMERA_OFF: camera_d = 1'b0;
        rfps_pkg::CMD_CHUTE: begin
          // fire once only
          if (!fired_q) begin
            fired_d = 1'b1;
            cnt_mid = pulse_q;
          end
        end
        default: ;
      endcase
    end

    chute_on    = (cnt_mid != '0);
    chute_cnt_d = chute_on ? cnt_mid - rfps_pkg::PULSE_W'(1) : cnt_mid;

    phase_d    = phase_q;
    prev_sum_d = prev_sum_q;
    start_ms_d = start_ms_q;
    case (phase_q)
      rfps_pkg::PH_WAITING: begin
        if (last_cmd_d == rfps_pkg::CMD_LAUNCH || frame_i.acc_sq >= launch_sq_q) begin
          phase_d = rfps_pkg::PH_POWERED;
        end
      end
      rfps_pkg::PH_POWERED: begin
        if (frame_i.acc_sq < burnout_sq_q) begin
          phase_d = rfps_pkg::PH_COAST;
        end
      end
      rfps_pkg::PH_COAST: begin
        // apogee: a full window summing above the previous full window
        if (wrap_i) begin
          if (prev_sum_q != '0 && sum_i > prev_sum_q) begin
            phase_d    = rfps_pkg::PH_DESCENT;
            start_ms_d = frame_i.time_ms;
          end else begin
            prev_sum_d = sum_i;
          end
        end
      end
      rfps_pkg::PH_DESCENT: begin
        if (elapsed > timeout_q) begin
          phase_d = rfps_pkg::PH_LANDED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rfps_pkg::PH_WAITING;
      last_cmd_q  <= '0;
      armed_q     <= 1'b0;
      camera_q    <= 1'b0;
      fired_q     <= 1'b0;
      chute_cnt_q <= '0;
      prev_sum_q  <= '0;
      start_ms_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (proc) begin
        phase_q     <= phase_d;
        last_cmd_q  <= last_cmd_d;
        armed_q     <= armed_d;
        camera_q    <= camera_d;
        fired_q     <= fired_d;
        chute_cnt_q <= chute_cnt_d;
        prev_sum_q  <= prev_sum_d;
        start_ms_q  <= start_ms_d;
      end
      if (ready_o) begin
        out_valid_q <= proc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_phase_q  <= phase_d;
      res_chute_q  <= chute_on;
      res_armed_q  <= armed_d;
      res_camera_q <= camera_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.flight_phase = res_phase_q;
  assign out_o.chute_on     = res_chute_q;
  assign out_o.armed_flag   = res_armed_q;
  assign out_o.camera_flag  = res_camera_q;

  a_landed_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rfps_pkg::PH_LANDED |=> phase_q == rfps_pkg::PH_LANDED)
    else $error("landed phase left");

  a_pulse_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chute_cnt_q != '0 |-> fired_q)
    else $error("chute pulse running without a firing");

  a_descent_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && phase_q == rfps_pkg::PH_COAST && phase_d == rfps_pkg::PH_DESCENT
    |=> phase_q == rfps_pkg::PH_DESCENT && start_ms_q == $past(frame_i.time_ms))
    else $error("descent entry time not captured");

endmodule

/* hw/rtl/rocket_flight_phase_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// rocket_flight_phase_sequencer_unit
// Flight phase sequencer: one result request for every frame request.
// ----------------------------------------------------------------------------
// A frame request is taken in every clock cycle while the result side keeps
// up. The three accelerometer squares and their sum are formed ahead of the
// input register. The command, chute, phase and pressure window update run
// between the input register and the result register. A result request is
// offered from the result register and holds until it is taken.
// With both registers full and the result side stalled, the input stalls too.
// The clock is set by the longer of two paths: the 16x16 squares with their
// three-way add, or the window add with the apogee compare. Configuration
// writes are taken at any time and apply to frames processed afterwards;
// write them while the unit is idle.
// ----------------------------------------------------------------------------
module rocket_flight_phase_sequencer_unit #(
  parameter int unsigned WINDOW_LEN = rfps_pkg::WINDOW_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfps_in_if.sink     in_i,
  rfps_cfg_if.sink    cfg_i,
  rfps_out_if.source  out_o
);

  localparam int unsigned SUM_W = rfps_pkg::PRESSURE_W + $clog2(WINDOW_LEN);

  logic                            frame_valid;
  logic                            frame_ready;
  rfps_pkg::frame_t                frame;
  logic                            push;
  logic [rfps_pkg::PRESSURE_W-1:0] pressure;
  logic                            wrap;
  logic [SUM_W-1:0]                sum;

  rfps_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (frame_valid),
    .frame_o (frame),
    .ready_i (frame_ready)
  );

  rfps_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pressure_i (pressure),
    .wrap_o     (wrap),
    .sum_o      (sum)
  );

  rfps_core #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (frame_valid),
    .frame_i    (frame),
    .ready_o    (frame_ready),
    .cfg_i      (cfg_i),
    .out_o      (out_o),
    .push_o     (push),
    .pressure_o (pressure),
    .wrap_i     (wrap),
    .sum_i      (sum)
  );

endmodule
